// File: rtl/okxc_pkg.sv
package okxc_pkg;

    localparam int KEY_CHARS_DEF     = 16;
    localparam int POSITION_BITS_DEF = 32;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int KEY_IDX_BITS   = 4;
    localparam int KEY_LEN_BITS   = 5;
    localparam int DICT_BITS      = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_KEY_LOW     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KEY_HIGH    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KEY_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXP_CHECK   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_HDR   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FORCED_LVL  = 3'd5;

    localparam logic [7:0] LEVEL_MASK   = 8'b1100_0000;
    localparam logic [7:0] LETTER_A     = 8'h41;
    localparam int         HEADER_BYTES = 8;
    localparam int         DICT_FIRST   = 4;
    localparam int         LEVEL_POS    = 2;
    localparam int         CHECK_FIRST  = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       checksum_ok;
    } out_item_t;

    typedef struct packed {
        logic [63:0]             key_word_low;
        logic [63:0]             key_word_high;
        logic [KEY_LEN_BITS-1:0] key_length;
        logic [7:0]              expected_checksum;
        logic                    level_from_header;
        logic [1:0]              forced_level;
    } cfg_t;

endpackage

// File: rtl/okxc_cfg.sv
module okxc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [okxc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [okxc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output okxc_pkg::cfg_t                       cfg
);
    import okxc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_LOW:    cfg_next.key_word_low      = cfg_data;
                CFG_KEY_HIGH:   cfg_next.key_word_high     = cfg_data;
                CFG_KEY_LENGTH: cfg_next.key_length        = cfg_data[KEY_LEN_BITS-1:0];
                CFG_EXP_CHECK:  cfg_next.expected_checksum = cfg_data[7:0];
                CFG_LEVEL_HDR:  cfg_next.level_from_header = cfg_data[0];
                CFG_FORCED_LVL: cfg_next.forced_level      = cfg_data[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_word_low      <= '0;
            cfg_reg.key_word_high     <= '0;
            cfg_reg.key_length        <= KEY_LEN_BITS'(1);
            cfg_reg.expected_checksum <= '0;
            cfg_reg.level_from_header <= 1'b1;
            cfg_reg.forced_level      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/okxc_stream.sv
module okxc_stream #(
    parameter int KEY_CHARS     = okxc_pkg::KEY_CHARS_DEF,
    parameter int POSITION_BITS = okxc_pkg::POSITION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  okxc_pkg::in_item_t   item,
    input  okxc_pkg::cfg_t       cfg,
    output okxc_pkg::out_item_t  result
);
    import okxc_pkg::*;

    localparam logic [KEY_LEN_BITS-1:0] KEY_LEN_MAX = KEY_LEN_BITS'(KEY_CHARS);
    localparam logic [POSITION_BITS-1:0] POS_MAX    = '1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [KEY_IDX_BITS-1:0]  key_idx_reg, key_idx_next;
    logic [1:0]               hdr_level_reg, hdr_level_next;
    logic [DICT_BITS-1:0]     dict_len_reg, dict_len_next;
    logic [7:0]               run_xor_reg, run_xor_next;

    logic [KEY_LEN_BITS-1:0]  key_len;
    logic [KEY_IDX_BITS-1:0]  key_used;
    logic [KEY_LEN_BITS-1:0]  key_used_inc;
    logic [127:0]             key_all;
    logic [7:0]               key_char;
    logic [1:0]               level;
    logic                     in_region;
    logic [7:0]               cipher_byte;
    logic [7:0]               out_byte;
    logic [7:0]               xor_new;

    always_comb
    begin
        if (cfg.key_length == '0)
            key_len = KEY_LEN_BITS'(1);
        else if (cfg.key_length > KEY_LEN_MAX)
            key_len = KEY_LEN_MAX;
        else
            key_len = cfg.key_length;

        key_used     = (KEY_LEN_BITS'(key_idx_reg) < key_len) ? key_idx_reg : '0;
        key_used_inc = KEY_LEN_BITS'(key_used) + KEY_LEN_BITS'(1);
        key_all      = {cfg.key_word_high, cfg.key_word_low};
        key_char     = key_all[key_used*8 +: 8];

        level     = cfg.level_from_header ? hdr_level_reg : cfg.forced_level;
        in_region = (pos_reg >= POSITION_BITS'(HEADER_BYTES))
                    && ((level == 2'd0)
                        || (pos_reg < POSITION_BITS'(dict_len_reg)
                                      + POSITION_BITS'(HEADER_BYTES)));

        cipher_byte = ((item.data_byte - LETTER_A) ^ (key_char - LETTER_A)) + LETTER_A;
        out_byte    = in_region ? cipher_byte : item.data_byte;

        xor_new = (pos_reg >= POSITION_BITS'(CHECK_FIRST)) ? (run_xor_reg ^ out_byte)
                                                           : run_xor_reg;

        result.out_byte    = out_byte;
        result.out_last    = item.is_last;
        result.checksum_ok = item.is_last && (xor_new == cfg.expected_checksum);
    end

    always_comb
    begin
        pos_next       = pos_reg;
        key_idx_next   = key_idx_reg;
        hdr_level_next = hdr_level_reg;
        dict_len_next  = dict_len_reg;
        run_xor_next   = run_xor_reg;
        if (step)
        begin
            if (item.is_last)
            begin
                pos_next       = '0;
                key_idx_next   = '0;
                hdr_level_next = '0;
                dict_len_next  = '0;
                run_xor_next   = '0;
            end
            else
            begin
                if (pos_reg == POSITION_BITS'(LEVEL_POS))
                    hdr_level_next = 2'((item.data_byte & LEVEL_MASK) >> 6);
                if ((pos_reg >= POSITION_BITS'(DICT_FIRST))
                    && (pos_reg < POSITION_BITS'(DICT_FIRST + 3)))
                    dict_len_next = {dict_len_reg[DICT_BITS-9:0], item.data_byte};
                run_xor_next = xor_new;
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POSITION_BITS'(1);
                key_idx_next = (key_used_inc >= key_len) ? '0
                                                         : key_used_inc[KEY_IDX_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            key_idx_reg   <= '0;
            hdr_level_reg <= '0;
            dict_len_reg  <= '0;
            run_xor_reg   <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            key_idx_reg   <= key_idx_next;
            hdr_level_reg <= hdr_level_next;
            dict_len_reg  <= dict_len_next;
            run_xor_reg   <= run_xor_next;
        end
    end

endmodule

// File: rtl/offset_xor_key_cipher_with_checksum_core.sv
// Repeating-key XOR cipher for a file byte stream with header parsing and a checksum
// check. Each accepted item is one file byte and gives exactly one result item. An item
// enters an input register, is ciphered and added to the checksum combinationally, and
// lands in the result register; one item per cycle is sustained while res_stall is low.
// The result passes both registers. While the result is stalled, one new item can still
// enter an empty input register. Configuration is written through cfg_write, cfg_index
// and cfg_data and must only change while no item is in flight. The item flagged is_last
// returns all stream state to reset, and the next item starts a new file.
module offset_xor_key_cipher_with_checksum_core #(
    parameter int KEY_CHARS     = okxc_pkg::KEY_CHARS_DEF,
    parameter int POSITION_BITS = okxc_pkg::POSITION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 byte_valid,
    output logic                                 byte_stall,
    input  okxc_pkg::in_item_t                   byte_item,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output okxc_pkg::out_item_t                  res_item,
    input  logic                                 cfg_write,
    input  logic [okxc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [okxc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import okxc_pkg::*;

    cfg_t      cfg;
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      res_valid_reg, res_valid_next;
    out_item_t res_item_reg;
    out_item_t stage_result;
    logic      res_free;
    logic      s1_advance;
    logic      byte_take;

    okxc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    okxc_stream #(
        .KEY_CHARS     (KEY_CHARS),
        .POSITION_BITS (POSITION_BITS)
    ) u_stream (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_advance),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (stage_result)
    );

    assign res_free   = !res_valid_reg || !res_stall;
    assign s1_advance = s1_valid_reg && res_free;
    assign byte_stall = s1_valid_reg && !res_free;
    assign byte_take  = byte_valid && !byte_stall;

    always_comb
    begin
        if (byte_take)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_advance)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
            s1_item_reg <= byte_item;
        if (s1_advance)
            res_item_reg <= stage_result;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // empty input stage never pushes back
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !byte_stall)
        else $error("stall raised with empty input stage");

    // an item leaving the input stage shows up as a result next cycle
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> (res_valid_reg && (res_item_reg == $past(stage_result))))
        else $error("advanced item missing from result register");

    // checksum flag only on the final item of a file
    a_ok_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (!res_item_reg.checksum_ok || res_item_reg.out_last))
        else $error("checksum flag on a non-final item");

endmodule
